// File: rtl/mcptt_pkg.sv
// Package for the multi-channel periodic tick timer.
// Holds field widths, reset values, function and register codes, and the sequencer states.
// No dependencies.
`default_nettype none

package mcptt_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int PERIOD_BITS_DEF = 16;

    localparam int FUNC_W    = 2;
    localparam int CHANNEL_W = 3;
    localparam int VALUE_W   = 16;
    localparam int ACTIVE_W  = 4;
    localparam int TPS_W     = 16;
    localparam int DIV_W     = 16;
    localparam int PREEMPT_W = 16;
    localparam int TICK_W    = 32;
    localparam int FIRED_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(18);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK         = 2'd0,
        FUNC_LOAD_PERIOD  = 2'd1,
        FUNC_LOAD_QUANTUM = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_CHANNELS  = 1'b0,
        REG_TICKS_PER_SECOND = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/multi_channel_periodic_tick_timer.sv
// Multi-channel periodic tick timer, top level.
// Depends on mcptt_pkg for widths, codes and states.
//
// Usage:
//   Input channel (in_valid/in_ready, func/channel/value) takes one transaction at a
//   time. A tick advances the tick count, the seconds divider, the preemption
//   countdown and the phase of each active channel; a load writes a channel period
//   (clearing its phase) or the preemption quantum.
//   Every transaction yields one result on the output channel (out_valid/out_ready).
//   Channel periods and phases live in one synchronous memory, one entry per channel,
//   swept with one read per cycle and a write-back in the cycle after each read.
//   A tick passes through the sweep state, one read per active channel (the active
//   channel count clamped to CHANNELS), then the drain and done states; a load, or a
//   tick with no active channel, goes straight to the done state. One transaction
//   is in work at a time; the next is accepted once the last leaves the done state.
//   in_ready is high while the sequencer is idle; a finished result waits in the
//   output register, and the next transaction is accepted meanwhile, then holds in
//   its final state until the output register frees.
//   Reset clears control state, not memory or results: entry valid bits mark every
//   channel as period zero, so no clearing pass is needed. Configuration is written
//   through cfg_we/cfg_index/cfg_data and must only change while the block is idle.
`default_nettype none

module multi_channel_periodic_tick_timer
    import mcptt_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FUNC_W-1:0]    func,
    input  wire logic [CHANNEL_W-1:0] channel,
    input  wire logic [VALUE_W-1:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FIRED_W-1:0]        fired_mask,
    output logic                      second_pulse,
    output logic                      preempt_expired,
    output logic                      resched_request,
    output logic [TICK_W-1:0]         tick_total
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = CW + 1;
    localparam int EW = 2 * PERIOD_BITS;

    state_t state_reg, state_next;

    logic [ACTIVE_W-1:0]    active_reg;
    logic [TPS_W-1:0]       tps_reg;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [PREEMPT_W-1:0]   preempt_reg, preempt_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                   rd_vld_reg;
    logic [CW-1:0]          rd_idx_reg;
    logic [EW-1:0]          rdata_reg;
    logic [CHANNELS-1:0]    ent_vld_reg;
    logic [FIRED_W-1:0]     fired_reg, fired_next;
    logic                   pulse_reg, pulse_next;
    logic                   expired_reg, expired_next;
    logic                   out_valid_reg;
    logic [FIRED_W-1:0]     fired_mask_reg;
    logic                   second_pulse_reg;
    logic                   preempt_expired_reg;
    logic                   resched_reg;
    logic [TICK_W-1:0]      tick_total_reg;

    logic [EW-1:0]          mem [CHANNELS];

    logic                   accept;
    logic                   is_tick;
    logic                   load_we;
    logic                   last_rd;
    logic                   done_fire;
    logic [EW-1:0]          ent;
    logic [PERIOD_BITS-1:0] ent_period;
    logic [PERIOD_BITS-1:0] ent_phase;
    logic [PERIOD_BITS-1:0] ph_inc;
    logic                   wb_fire;
    logic                   wb_we;
    logic [FIRED_W-1:0]     fire_bits;
    logic [DIV_W-1:0]       div_inc;
    logic                   mem_we;
    logic [CW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [CW-1:0]          load_addr;

    // Handshake and sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    assign accept  = in_valid && in_ready;
    assign is_tick = (func == FUNC_TICK);
    assign last_rd = (NW'(rd_cnt_reg + 1'b1) == n_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_tick && (n_next != '0))
                        state_next = S_SWEEP;
                    else
                        state_next = S_DONE;
                end
            end
            S_SWEEP:
            begin
                if (last_rd)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_DONE;
            S_DONE:
            begin
                if (done_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Write-back stage: entry read in the cycle before
    always_comb
    begin
        ent        = ent_vld_reg[rd_idx_reg] ? rdata_reg : '0;
        ent_period = ent[EW-1:PERIOD_BITS];
        ent_phase  = ent[PERIOD_BITS-1:0];
        ph_inc     = PERIOD_BITS'(ent_phase + 1'b1);
        wb_we      = rd_vld_reg && (ent_period != '0);
        wb_fire    = wb_we && (ph_inc == ent_period);
        fire_bits  = '0;
        for (int k = 0; k < FIRED_W; k++)
        begin
            if (wb_fire && (32'(rd_idx_reg) == k))
                fire_bits[k] = 1'b1;
        end
    end

    assign load_addr = CW'(channel);
    assign load_we   = accept && (func == FUNC_LOAD_PERIOD) && (32'(channel) < CHANNELS);

    always_comb
    begin
        mem_we    = wb_we || load_we;
        mem_waddr = wb_we ? rd_idx_reg : load_addr;
        if (wb_we)
            mem_wdata = {ent_period, (wb_fire ? {PERIOD_BITS{1'b0}} : ph_inc)};
        else
            mem_wdata = {PERIOD_BITS'(value), {PERIOD_BITS{1'b0}}};
    end

    // Tick counters, preemption and result bookkeeping
    always_comb
    begin
        div_inc      = DIV_W'(div_reg + 1'b1);
        div_next     = div_reg;
        preempt_next = preempt_reg;
        tick_next    = tick_reg;
        n_next       = n_reg;
        rd_cnt_next  = rd_cnt_reg;
        fired_next   = fired_reg | fire_bits;
        pulse_next   = pulse_reg;
        expired_next = expired_reg;
        if (32'(active_reg) > CHANNELS)
            n_next = NW'(CHANNELS);
        else
            n_next = NW'(active_reg);
        if (accept)
        begin
            rd_cnt_next  = '0;
            fired_next   = '0;
            pulse_next   = 1'b0;
            expired_next = 1'b0;
            case (func)
                FUNC_TICK:
                begin
                    tick_next = TICK_W'(tick_reg + 1'b1);
                    if (div_inc >= tps_reg)
                    begin
                        div_next   = '0;
                        pulse_next = 1'b1;
                    end
                    else
                    begin
                        div_next = div_inc;
                    end
                    expired_next = (preempt_reg <= PREEMPT_W'(1));
                    if (preempt_reg != '0)
                        preempt_next = PREEMPT_W'(preempt_reg - 1'b1);
                end
                FUNC_LOAD_QUANTUM:
                    preempt_next = value;
                default:
                    ;
            endcase
        end
        else if (state_reg == S_SWEEP)
        begin
            rd_cnt_next = NW'(rd_cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            tps_reg       <= TPS_RESET;
            div_reg       <= '0;
            preempt_reg   <= '0;
            tick_reg      <= '0;
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            ent_vld_reg   <= '0;
            fired_reg     <= '0;
            pulse_reg     <= 1'b0;
            expired_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_reg     <= div_next;
            preempt_reg <= preempt_next;
            tick_reg    <= tick_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_vld_reg  <= (state_reg == S_SWEEP);
            fired_reg   <= fired_next;
            pulse_reg   <= pulse_next;
            expired_reg <= expired_next;
            if (accept)
                n_reg <= n_next;
            if (load_we)
                ent_vld_reg[load_addr] <= 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACTIVE_CHANNELS:  active_reg <= ACTIVE_W'(cfg_data);
                    REG_TICKS_PER_SECOND: tps_reg    <= TPS_W'(cfg_data);
                    default:              ;
                endcase
            end
            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Channel memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg  <= mem[rd_cnt_reg[CW-1:0]];
        rd_idx_reg <= rd_cnt_reg[CW-1:0];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            fired_mask_reg      <= fired_reg;
            second_pulse_reg    <= pulse_reg;
            preempt_expired_reg <= expired_reg;
            resched_reg         <= (fired_reg != '0) || expired_reg;
            tick_total_reg      <= tick_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign fired_mask      = fired_mask_reg;
    assign second_pulse    = second_pulse_reg;
    assign preempt_expired = preempt_expired_reg;
    assign resched_request = resched_reg;
    assign tick_total      = tick_total_reg;

`ifndef SYNTHESIS
    a_rd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SWEEP || state_reg == S_DRAIN))
        else $error("write-back stage active outside sweep");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (rd_cnt_reg < n_reg))
        else $error("sweep read index past active count");

    a_wb_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we |-> !load_we)
        else $error("write-back collides with period load");

    a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick) |=> (tick_reg == TICK_W'($past(tick_reg) + 1'b1)))
        else $error("tick count did not advance");
`endif

endmodule

`default_nettype wire
